[hdl/camu_pkg.sv]
`default_nettype none
package camu_pkg;

  // addressing mode codes
  localparam logic [3:0] AM_ABS  = 4'd0;
  localparam logic [3:0] AM_ABSX = 4'd1;
  localparam logic [3:0] AM_ABSY = 4'd2;
  localparam logic [3:0] AM_IMPL = 4'd3;
  localparam logic [3:0] AM_IMM  = 4'd4;
  localparam logic [3:0] AM_IND  = 4'd5;
  localparam logic [3:0] AM_INDX = 4'd6;
  localparam logic [3:0] AM_INDY = 4'd7;
  localparam logic [3:0] AM_REL  = 4'd8;
  localparam logic [3:0] AM_ZP   = 4'd9;
  localparam logic [3:0] AM_ZPX  = 4'd10;
  localparam logic [3:0] AM_ZPY  = 4'd11;

  // result kinds
  localparam logic [1:0] KIND_FINAL      = 2'd0;
  localparam logic [1:0] KIND_FETCH      = 2'd1;
  localparam logic [1:0] KIND_NONE       = 2'd2;
  localparam logic [1:0] KIND_UNEXPECTED = 2'd3;

  // pending indirect codes
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_IND  = 2'd1;
  localparam logic [1:0] PEND_INDX = 2'd2;
  localparam logic [1:0] PEND_INDY = 2'd3;

  // word kinds on the input channel
  localparam logic MODE_INSTR   = 1'b0;
  localparam logic MODE_POINTER = 1'b1;

  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_TWO   = 2'd2;
  localparam logic [1:0] LEN_THREE = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [3:0]  addr_mode;
    logic [15:0] pc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  accumulator;
    logic [7:0]  operand_low;
    logic [7:0]  operand_high;
    logic [7:0]  pointer_low;
    logic [7:0]  pointer_high;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [15:0] pointer_low_addr;
    logic [15:0] pointer_high_addr;
    logic [1:0]  op_length;
    logic        read_extra_cycle;
    logic        write_extra_cycle;
    logic [7:0]  temp_value;
  } out_item_t;

  typedef struct packed {
    logic [1:0] pending;
    logic [7:0] saved_y;
    logic [1:0] saved_length;
  } ptr_state_t;

endpackage
`default_nettype wire

[hdl/camu_ea_calc.sv]
`default_nettype none
module camu_ea_calc
  import camu_pkg::*;
(
  input  wire in_item_t   item,
  input  wire ptr_state_t state,
  output out_item_t       res,
  output ptr_state_t      state_nxt
);

  logic [15:0] word;
  logic [15:0] ptr;
  logic [15:0] ptr_y;
  logic [15:0] idx_sum;
  logic [15:0] pc_next;
  logic [15:0] rel_tgt;
  logic [7:0]  lo_x;
  logic [7:0]  lo_x1;
  logic [7:0]  lo_1;
  logic [7:0]  lo_y;

  assign word    = {item.operand_high, item.operand_low};
  assign ptr     = {item.pointer_high, item.pointer_low};
  assign ptr_y   = ptr + {8'd0, state.saved_y};
  assign idx_sum = word + {8'd0, (item.addr_mode == AM_ABSX) ? item.index_x : item.index_y};
  assign pc_next = item.pc + 16'd2;
  assign rel_tgt = pc_next + {{8{item.operand_low[7]}}, item.operand_low};
  assign lo_x    = item.operand_low + item.index_x;
  assign lo_x1   = lo_x + 8'd1;
  assign lo_1    = item.operand_low + 8'd1;
  assign lo_y    = item.operand_low + item.index_y;

  always_comb begin
    res       = '0;
    res.kind  = KIND_FINAL;
    state_nxt = state;
    state_nxt.pending = PEND_NONE;
    if (item.mode == MODE_POINTER) begin
      if (state.pending == PEND_NONE) begin
        res.kind = KIND_UNEXPECTED;
      end else begin
        res.op_length = state.saved_length;
        if (state.pending == PEND_INDY) begin
          res.address           = ptr_y;
          res.read_extra_cycle  = (ptr_y[15:8] != ptr[15:8]);
          res.write_extra_cycle = 1'b1;
        end else begin
          res.address = ptr;
        end
      end
    end else begin
      unique case (item.addr_mode)
        AM_ABS: begin
          res.address   = word;
          res.op_length = LEN_THREE;
        end
        AM_ABSX, AM_ABSY: begin
          res.address           = idx_sum;
          res.read_extra_cycle  = (idx_sum[15:8] != word[15:8]);
          res.write_extra_cycle = 1'b1;
          res.op_length         = LEN_THREE;
        end
        AM_IMM: begin
          res.address   = item.pc + 16'd1;
          res.op_length = LEN_TWO;
        end
        AM_IND: begin
          res.kind              = KIND_FETCH;
          res.op_length         = LEN_THREE;
          res.pointer_low_addr  = word;
          res.pointer_high_addr = word + 16'd1;
          state_nxt.pending      = PEND_IND;
          state_nxt.saved_length = LEN_THREE;
        end
        AM_INDX: begin
          res.kind              = KIND_FETCH;
          res.op_length         = LEN_TWO;
          res.pointer_low_addr  = {8'd0, lo_x};
          res.pointer_high_addr = {8'd0, lo_x1};
          state_nxt.pending      = PEND_INDX;
          state_nxt.saved_length = LEN_TWO;
        end
        AM_INDY: begin
          res.kind              = KIND_FETCH;
          res.op_length         = LEN_TWO;
          res.pointer_low_addr  = {8'd0, item.operand_low};
          res.pointer_high_addr = {8'd0, lo_1};
          state_nxt.pending      = PEND_INDY;
          state_nxt.saved_length = LEN_TWO;
          state_nxt.saved_y      = item.index_y;
        end
        AM_REL: begin
          res.address          = rel_tgt;
          res.read_extra_cycle = (rel_tgt[15:8] != pc_next[15:8]);
          res.op_length        = LEN_TWO;
        end
        AM_ZP: begin
          res.address   = {8'd0, item.operand_low};
          res.op_length = LEN_TWO;
        end
        AM_ZPX: begin
          res.address   = {8'd0, lo_x};
          res.op_length = LEN_TWO;
        end
        AM_ZPY: begin
          res.address   = {8'd0, lo_y};
          res.op_length = LEN_TWO;
        end
        default: begin
          // implied, and the unused codes
          res.kind       = KIND_NONE;
          res.op_length  = LEN_ONE;
          res.temp_value = item.accumulator;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/camu_ptr_state.sv]
`default_nettype none
module camu_ptr_state
  import camu_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             adv,
  input  wire ptr_state_t state_nxt,
  output ptr_state_t      state
);

  ptr_state_t state_r;

  // update only when a word leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (adv) begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule
`default_nettype wire

[hdl/cpu_addressing_mode_unit.sv]
`default_nettype none
// Channel   Ports                          Word
// input     in_valid in_ready in_data      in_item_t
// result    out_valid out_ready out_data   out_item_t
//
// One result word per input word; out_valid rises when the word moves from the input
// register through the address logic into the result register once that register frees.
// Sustained rate is one word per cycle while out_ready is high.
// Reset clears both valid flags and the pending pointer state.
// A stalled result holds in its register; the input register keeps taking
// a word whenever the result register frees or is taken in the same cycle.
module cpu_addressing_mode_unit
  import camu_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire in_item_t in_data,
  output logic         out_valid,
  input  wire          out_ready,
  output out_item_t    out_data
);

  in_item_t   in_r;
  logic       in_valid_r;
  out_item_t  out_r;
  logic       out_valid_r;
  logic       adv;
  out_item_t  res;
  ptr_state_t state;
  ptr_state_t state_nxt;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  camu_ea_calc u_calc (
    .item      (in_r),
    .state     (state),
    .res       (res),
    .state_nxt (state_nxt)
  );

  camu_ptr_state u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .state_nxt (state_nxt),
    .state     (state)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_fetch_no_flags : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_FETCH) |->
      (!out_r.read_extra_cycle && !out_r.write_extra_cycle && out_r.address == 16'd0))
    else $error("fetch request carries flags or address");

  a_unexp_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_UNEXPECTED) |->
      (out_r.address == 16'd0 && out_r.op_length == 2'd0 && out_r.temp_value == 8'd0))
    else $error("unexpected pointer word has nonzero fields");

  a_fetch_sets_pending : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.kind == KIND_FETCH) |=> (state.pending != PEND_NONE))
    else $error("fetch request did not leave a pending pointer");

  a_done_clears_pending : assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.kind != KIND_FETCH) |=> (state.pending == PEND_NONE))
    else $error("pending pointer not cleared");

endmodule
`default_nettype wire
